### hw/rtl/tvf_pkg.sv
// ----------------------------------------------------------------------------
// tvf_pkg
// Shared types and constants of the tag/value field encoder.
// ----------------------------------------------------------------------------
package tvf_pkg;

    localparam int unsigned OP_W        = 2;
    localparam int unsigned TAG_W       = 32;
    localparam int unsigned TYPE_W      = 3;
    localparam int unsigned VALUE_W     = 64;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned DIGIT_W     = 7;

    // 64-bit value gives at most ten base-128 digits
    localparam int unsigned STACK_DEPTH = 10;
    localparam int unsigned STACK_IDX_W = 4;
    localparam int unsigned STACK_CNT_W = 4;
    localparam int unsigned RAW_CNT_W   = 3;

    localparam int unsigned S_TDATA_W   = 104;

    localparam logic [BYTE_W-1:0]  HDR_ESCAPE       = 8'hF8;
    localparam logic [BYTE_W-1:0]  CONT_BIT         = 8'h80;
    localparam logic [TAG_W-1:0]   TAG_INLINE_LIMIT = 32'd31;

    typedef enum logic [OP_W-1:0] {
        OP_VARINT  = 2'd0,
        OP_HEADER  = 2'd1,
        OP_RAW64   = 2'd2,
        OP_PAYLOAD = 2'd3
    } t_op;

    // control from the sequencer to the digit unit
    typedef struct packed {
        logic                 load;
        logic                 step;
        logic [VALUE_W-1:0]   load_val;
    } t_unit_ctl;

    // control from the sequencer to the digit stack
    typedef struct packed {
        logic                 push;
        logic                 pop;
        logic [BYTE_W-1:0]    data;
    } t_stack_ctl;

endpackage

### hw/rtl/tvf_digit_unit.sv
// ----------------------------------------------------------------------------
// tvf_digit_unit
// Shared base-128 digit unit: peels one bijective digit off the remainder
// per step, least significant digit first.
// ----------------------------------------------------------------------------
module tvf_digit_unit
    import tvf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_unit_ctl          i_ctl,
    output logic [BYTE_W-1:0]  o_digit,
    output logic               o_done
);

    logic [VALUE_W-1:0] r_rem;
    logic               r_first;

    // Mark every digit but the lowest one with the continuation bit
    assign o_digit = {1'b0, r_rem[DIGIT_W-1:0]} | (r_first ? '0 : CONT_BIT);
    assign o_done  = (r_rem[VALUE_W-1:DIGIT_W] == '0);

    // Load a new value or advance to the next higher digit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (i_ctl.load) begin
            r_first <= 1'b1;
        end else if (i_ctl.step) begin
            r_first <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem <= i_ctl.load_val;
        end else if (i_ctl.step) begin
            r_rem <= (r_rem >> DIGIT_W) - VALUE_W'(1);
        end
    end

endmodule

### hw/rtl/tvf_digit_stack.sv
// ----------------------------------------------------------------------------
// tvf_digit_stack
// Last-in first-out store that turns the digit order around, so that the
// most significant digit leaves first.
// ----------------------------------------------------------------------------
module tvf_digit_stack
    import tvf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_stack_ctl              i_ctl,
    output logic [BYTE_W-1:0]       o_top,
    output logic [STACK_CNT_W-1:0]  o_count
);

    logic [BYTE_W-1:0]      r_mem [STACK_DEPTH];
    logic [STACK_CNT_W-1:0] r_cnt;
    logic [STACK_IDX_W-1:0] top_idx;

    assign top_idx = STACK_IDX_W'(r_cnt - STACK_CNT_W'(1));
    assign o_top   = r_mem[top_idx];
    assign o_count = r_cnt;

    // Track fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.push) begin
            r_cnt <= r_cnt + STACK_CNT_W'(1);
        end else if (i_ctl.pop) begin
            r_cnt <= r_cnt - STACK_CNT_W'(1);
        end
    end

    // Write the pushed digit at the current fill level
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[STACK_IDX_W'(r_cnt)] <= i_ctl.data;
        end
    end

endmodule

### hw/rtl/tag_value_field_encoder.sv
// ----------------------------------------------------------------------------
// tag_value_field_encoder
// Encodes one tagged field per input transfer into a run of bytes.
// ----------------------------------------------------------------------------
// Usage: the slave channel takes one field per transfer; tuser carries the
// operation (varint value, header only, 8 raw bytes, payload byte) and tdata
// the tag, type code and value. The master channel sends the encoded bytes
// one per transfer, with tlast on the final byte of each field.
// After acceptance the header state loads the header byte (for a payload
// operation the payload byte) into the output register. Each varint (long
// tag or value) first runs through the shared digit unit, one digit per
// cycle, then its digits leave from the digit stack one per cycle while
// the master side is ready. The slave side is ready only between items. A
// stalled master side holds the current byte in the output register and
// pauses the sequencer; digit conversion continues until a byte has to
// leave. Synchronous reset drops any item in progress and clears the
// output valid flag.
// ----------------------------------------------------------------------------
module tag_value_field_encoder
    import tvf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // tag [31:0], type_code [34:32], value [98:35], zero fill above
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    // operation [1:0]
    input  logic [OP_W-1:0]       i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // out_byte [7:0]
    output logic [BYTE_W-1:0]     o_m_tdata,
    output logic                  o_m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_CONV,
        ST_EMIT,
        ST_RAW
    } t_state;

    t_state                  r_state,     n_state;
    t_op                     r_op,        n_op;
    logic [TAG_W-1:0]        r_tag,       n_tag;
    logic [TYPE_W-1:0]       r_type,      n_type;
    logic [VALUE_W-1:0]      r_value,     n_value;
    logic [RAW_CNT_W-1:0]    r_raw_cnt,   n_raw_cnt;
    logic                    r_on_tag,    n_on_tag;
    logic                    r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]       r_out_byte,  n_out_byte;
    logic                    r_out_last,  n_out_last;

    t_unit_ctl               unit_ctl;
    t_stack_ctl              stack_ctl;
    logic [BYTE_W-1:0]       unit_digit;
    logic                    unit_done;
    logic [BYTE_W-1:0]       stack_top;
    logic [STACK_CNT_W-1:0]  stack_cnt;
    logic                    can_emit;
    logic                    s_accept;

    tvf_digit_unit u_digit_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (unit_ctl),
        .o_digit (unit_digit),
        .o_done  (unit_done)
    );

    tvf_digit_stack u_digit_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (stack_ctl),
        .o_top   (stack_top),
        .o_count (stack_cnt)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign can_emit   = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;

    // Sequence header, payload byte, varint digits and raw bytes
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_tag       = r_tag;
        n_type      = r_type;
        n_value     = r_value;
        n_raw_cnt   = r_raw_cnt;
        n_on_tag    = r_on_tag;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        unit_ctl    = '0;
        stack_ctl   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_op    = t_op'(i_s_tuser);
                    n_tag   = i_s_tdata[TAG_W-1:0];
                    n_type  = i_s_tdata[TAG_W +: TYPE_W];
                    n_value = i_s_tdata[TAG_W+TYPE_W +: VALUE_W];
                    n_state = ST_HDR;
                end
            end

            ST_HDR: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_raw_cnt   = '0;
                    if (r_op == OP_PAYLOAD) begin
                        n_out_byte = r_value[BYTE_W-1:0];
                        n_out_last = 1'b1;
                        n_state    = ST_IDLE;
                    end else if (r_tag < TAG_INLINE_LIMIT) begin
                        n_out_byte = {r_tag[BYTE_W-TYPE_W-1:0], r_type};
                        n_out_last = (r_op == OP_HEADER);
                        unique case (r_op)
                            OP_VARINT: begin
                                unit_ctl.load     = 1'b1;
                                unit_ctl.load_val = r_value;
                                n_on_tag          = 1'b0;
                                n_state           = ST_CONV;
                            end
                            OP_RAW64: n_state = ST_RAW;
                            default:  n_state = ST_IDLE;
                        endcase
                    end else begin
                        n_out_byte        = HDR_ESCAPE | BYTE_W'(r_type);
                        n_out_last        = 1'b0;
                        unit_ctl.load     = 1'b1;
                        unit_ctl.load_val = VALUE_W'(r_tag);
                        n_on_tag          = 1'b1;
                        n_state           = ST_CONV;
                    end
                end
            end

            ST_CONV: begin
                // push one digit per cycle, lowest first
                stack_ctl.push = 1'b1;
                stack_ctl.data = unit_digit;
                if (unit_done) begin
                    n_state = ST_EMIT;
                end else begin
                    unit_ctl.step = 1'b1;
                end
            end

            ST_EMIT: begin
                if (can_emit) begin
                    stack_ctl.pop = 1'b1;
                    n_out_valid   = 1'b1;
                    n_out_byte    = stack_top;
                    n_out_last    = 1'b0;
                    if (stack_cnt == STACK_CNT_W'(1)) begin
                        if (!r_on_tag || r_op == OP_HEADER) begin
                            n_out_last = 1'b1;
                            n_state    = ST_IDLE;
                        end else if (r_op == OP_RAW64) begin
                            n_state = ST_RAW;
                        end else begin
                            unit_ctl.load     = 1'b1;
                            unit_ctl.load_val = r_value;
                            n_on_tag          = 1'b0;
                            n_state           = ST_CONV;
                        end
                    end
                end
            end

            ST_RAW: begin
                // send the value little-endian, one byte per transfer
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_value[BYTE_W-1:0];
                    n_value     = r_value >> BYTE_W;
                    n_raw_cnt   = r_raw_cnt + RAW_CNT_W'(1);
                    n_out_last  = (r_raw_cnt == '1);
                    if (r_raw_cnt == '1) begin
                        n_state = ST_IDLE;
                    end
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // Hold state and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_on_tag    <= 1'b0;
            r_raw_cnt   <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_on_tag    <= n_on_tag;
            r_raw_cnt   <= n_raw_cnt;
        end
        r_op       <= n_op;
        r_tag      <= n_tag;
        r_type     <= n_type;
        r_value    <= n_value;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

endmodule
